[rtl/rgb2yuv_pkg.sv]
package rgb2yuv_pkg;

    localparam int PixelWidthDefault = 16;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 4;
    localparam int ChanWidth     = 8;
    localparam int CoefWidth     = 16;
    localparam int ProdWidth     = ChanWidth + CoefWidth;
    localparam int SumWidth      = ProdWidth + 1;
    localparam int FracBits      = 16;

    localparam logic [CfgIndexWidth-1:0] REG_RED_SHIFT   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RED_LOSS    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_GREEN_SHIFT = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_GREEN_LOSS  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_BLUE_SHIFT  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_BLUE_LOSS   = 3'd5;

    localparam logic [CfgDataWidth-1:0] RED_SHIFT_RESET   = 4'd11;
    localparam logic [CfgDataWidth-1:0] RED_LOSS_RESET    = 4'd3;
    localparam logic [CfgDataWidth-1:0] GREEN_SHIFT_RESET = 4'd5;
    localparam logic [CfgDataWidth-1:0] GREEN_LOSS_RESET  = 4'd2;
    localparam logic [CfgDataWidth-1:0] BLUE_SHIFT_RESET  = 4'd0;
    localparam logic [CfgDataWidth-1:0] BLUE_LOSS_RESET   = 4'd3;

    // coefficient magnitudes, 0.16 fixed point
    localparam logic [CoefWidth-1:0] Y_R = 16'd19595;
    localparam logic [CoefWidth-1:0] Y_G = 16'd38470;
    localparam logic [CoefWidth-1:0] Y_B = 16'd7471;
    localparam logic [CoefWidth-1:0] U_R = 16'd11076;
    localparam logic [CoefWidth-1:0] U_G = 16'd21692;
    localparam logic [CoefWidth-1:0] U_B = 16'd32768;
    localparam logic [CoefWidth-1:0] V_R = 16'd32768;
    localparam logic [CoefWidth-1:0] V_G = 16'd27460;
    localparam logic [CoefWidth-1:0] V_B = 16'd5308;

    localparam logic [ChanWidth-1:0] CHROMA_OFFSET = 8'd128;
    localparam logic [SumWidth-1:0]  ROUND_TO_ZERO = SumWidth'((1 << FracBits) - 1);

endpackage

[rtl/rgb16_to_yuv_convert.sv]
// channel    | ports                                         | transaction
// -----------+-----------------------------------------------+---------------------------
// pixel in   | start, busy, pixel                            | start high and busy low
// result out | done, luma, chroma_blue, chroma_red           | done high, one cycle
// config     | write_enable, write_index, write_data         | write_enable high
//
// four register stages: channel extract, products, sums, truncate and offset.
// one pixel per clock; each result passes through all four register stages before done rises.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// rst_n clears the stage valid bits and loads the layout registers (565 layout).
module rgb16_to_yuv_convert #(
    parameter int PIXEL_WIDTH = rgb2yuv_pkg::PixelWidthDefault
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [PIXEL_WIDTH-1:0]               pixel,
    input  logic                                 write_enable,
    input  logic [rgb2yuv_pkg::CfgIndexWidth-1:0] write_index,
    input  logic [rgb2yuv_pkg::CfgDataWidth-1:0]  write_data,
    output logic                                 done,
    output logic [rgb2yuv_pkg::ChanWidth-1:0]     luma,
    output logic [rgb2yuv_pkg::ChanWidth-1:0]     chroma_blue,
    output logic [rgb2yuv_pkg::ChanWidth-1:0]     chroma_red
);

    localparam int CW = rgb2yuv_pkg::ChanWidth;
    localparam int DW = rgb2yuv_pkg::CfgDataWidth;
    localparam int PW = rgb2yuv_pkg::ProdWidth;
    localparam int SW = rgb2yuv_pkg::SumWidth;
    localparam int FB = rgb2yuv_pkg::FracBits;

    logic [DW-1:0] red_shift_reg, red_loss_reg;
    logic [DW-1:0] green_shift_reg, green_loss_reg;
    logic [DW-1:0] blue_shift_reg, blue_loss_reg;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [CW-1:0] red_reg, green_reg, blue_reg;
    logic [CW-1:0] red_next, green_next, blue_next;

    logic [PW-1:0] yr_reg, yg_reg, yb_reg;
    logic [PW-1:0] ur_reg, ug_reg, ub_reg;
    logic [PW-1:0] vr_reg, vg_reg, vb_reg;

    logic [PW-1:0]        y_sum_reg, y_sum_next;
    logic signed [SW-1:0] u_sum_reg, u_sum_next, v_sum_reg, v_sum_next;
    logic signed [SW-1:0] u_adj, v_adj;

    logic [CW-1:0] luma_reg, chroma_blue_reg, chroma_red_reg;
    logic [CW-1:0] luma_next, chroma_blue_next, chroma_red_next;

    logic accept;

    function automatic logic [CW-1:0] channel_byte(
        input logic [PIXEL_WIDTH-1:0] pix,
        input logic [DW-1:0]          shift,
        input logic [DW-1:0]          loss
    );
        logic [PIXEL_WIDTH-1:0] moved;
        logic [CW-1:0]          field;
        moved = pix >> shift;
        field = moved[CW-1:0] & (CW'(8'hFF) >> loss);
        return field << loss;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // layout registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_shift_reg   <= rgb2yuv_pkg::RED_SHIFT_RESET;
            red_loss_reg    <= rgb2yuv_pkg::RED_LOSS_RESET;
            green_shift_reg <= rgb2yuv_pkg::GREEN_SHIFT_RESET;
            green_loss_reg  <= rgb2yuv_pkg::GREEN_LOSS_RESET;
            blue_shift_reg  <= rgb2yuv_pkg::BLUE_SHIFT_RESET;
            blue_loss_reg   <= rgb2yuv_pkg::BLUE_LOSS_RESET;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                rgb2yuv_pkg::REG_RED_SHIFT:   red_shift_reg   <= write_data;
                rgb2yuv_pkg::REG_RED_LOSS:    red_loss_reg    <= write_data;
                rgb2yuv_pkg::REG_GREEN_SHIFT: green_shift_reg <= write_data;
                rgb2yuv_pkg::REG_GREEN_LOSS:  green_loss_reg  <= write_data;
                rgb2yuv_pkg::REG_BLUE_SHIFT:  blue_shift_reg  <= write_data;
                rgb2yuv_pkg::REG_BLUE_LOSS:   blue_loss_reg   <= write_data;
                default:
                begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: channel extract
    always_comb
    begin
        red_next   = channel_byte(pixel, red_shift_reg, red_loss_reg);
        green_next = channel_byte(pixel, green_shift_reg, green_loss_reg);
        blue_next  = channel_byte(pixel, blue_shift_reg, blue_loss_reg);
    end

    // stage 3 sums and stage 4 truncation toward zero
    always_comb
    begin
        y_sum_next = yr_reg + yg_reg + yb_reg;
        u_sum_next = $signed({1'b0, ub_reg}) - $signed({1'b0, ur_reg})
                   - $signed({1'b0, ug_reg});
        v_sum_next = $signed({1'b0, vr_reg}) - $signed({1'b0, vg_reg})
                   - $signed({1'b0, vb_reg});
        u_adj = u_sum_reg[SW-1] ? u_sum_reg + $signed(rgb2yuv_pkg::ROUND_TO_ZERO) : u_sum_reg;
        v_adj = v_sum_reg[SW-1] ? v_sum_reg + $signed(rgb2yuv_pkg::ROUND_TO_ZERO) : v_sum_reg;
        luma_next        = y_sum_reg[FB +: CW];
        chroma_blue_next = u_adj[FB +: CW] + rgb2yuv_pkg::CHROMA_OFFSET;
        chroma_red_next  = v_adj[FB +: CW] + rgb2yuv_pkg::CHROMA_OFFSET;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;

        yr_reg <= red_reg   * rgb2yuv_pkg::Y_R;
        yg_reg <= green_reg * rgb2yuv_pkg::Y_G;
        yb_reg <= blue_reg  * rgb2yuv_pkg::Y_B;
        ur_reg <= red_reg   * rgb2yuv_pkg::U_R;
        ug_reg <= green_reg * rgb2yuv_pkg::U_G;
        ub_reg <= blue_reg  * rgb2yuv_pkg::U_B;
        vr_reg <= red_reg   * rgb2yuv_pkg::V_R;
        vg_reg <= green_reg * rgb2yuv_pkg::V_G;
        vb_reg <= blue_reg  * rgb2yuv_pkg::V_B;

        y_sum_reg <= y_sum_next;
        u_sum_reg <= u_sum_next;
        v_sum_reg <= v_sum_next;

        luma_reg        <= luma_next;
        chroma_blue_reg <= chroma_blue_next;
        chroma_red_reg  <= chroma_red_next;
    end

    assign done        = s4_valid_reg;
    assign luma        = luma_reg;
    assign chroma_blue = chroma_blue_reg;
    assign chroma_red  = chroma_red_reg;

endmodule

[bench/rgb16_yuv_checker.sv]
`timescale 1ns / 1ps
module rgb16_yuv_checker #(
    parameter int PIXEL_WIDTH = rgb2yuv_pkg::PixelWidthDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [PIXEL_WIDTH-1:0]                pixel,
    input  logic                                  write_enable,
    input  logic [rgb2yuv_pkg::CfgIndexWidth-1:0] write_index,
    input  logic [rgb2yuv_pkg::CfgDataWidth-1:0]  write_data,
    input  logic                                  done,
    input  logic [rgb2yuv_pkg::ChanWidth-1:0]     luma,
    input  logic [rgb2yuv_pkg::ChanWidth-1:0]     chroma_blue,
    input  logic [rgb2yuv_pkg::ChanWidth-1:0]     chroma_red,
    output int                                    outstanding,
    output int                                    mismatches
);

    localparam int CW = rgb2yuv_pkg::ChanWidth;
    localparam int DW = rgb2yuv_pkg::CfgDataWidth;

    localparam int LUMA_R = 19595;
    localparam int LUMA_G = 38470;
    localparam int LUMA_B = 7471;
    localparam int CB_R   = -11076;
    localparam int CB_G   = -21692;
    localparam int CB_B   = 32768;
    localparam int CR_R   = 32768;
    localparam int CR_G   = -27460;
    localparam int CR_B   = -5308;
    localparam int Q16    = 65536;
    localparam int OFFSET = 128;

    typedef struct packed {
        logic [CW-1:0] luma;
        logic [CW-1:0] cb;
        logic [CW-1:0] cr;
    } yuv_t;

    logic [DW-1:0] red_shift_reg, red_loss_reg;
    logic [DW-1:0] green_shift_reg, green_loss_reg;
    logic [DW-1:0] blue_shift_reg, blue_loss_reg;

    yuv_t yuv_expected[$];
    int   err_count = 0;

    assign mismatches = err_count;

    // masked field, shifted down, widened back to a byte
    function automatic logic [CW-1:0] channel_of(input logic [PIXEL_WIDTH-1:0] pix,
                                                 input logic [DW-1:0] shift,
                                                 input logic [DW-1:0] loss);
        logic [31:0] field;
        field = (32'(pix) & ((32'd255 >> loss) << shift)) >> shift;
        return CW'(field << loss);
    endfunction

    // integer division truncates toward zero, as the block does
    function automatic yuv_t convert(input logic [PIXEL_WIDTH-1:0] pix);
        int   r, g, b;
        yuv_t res;
        r = int'(channel_of(pix, red_shift_reg, red_loss_reg));
        g = int'(channel_of(pix, green_shift_reg, green_loss_reg));
        b = int'(channel_of(pix, blue_shift_reg, blue_loss_reg));
        res.luma = CW'((LUMA_R * r + LUMA_G * g + LUMA_B * b) / Q16);
        res.cb   = CW'((CB_R * r + CB_G * g + CB_B * b) / Q16 + OFFSET);
        res.cr   = CW'((CR_R * r + CR_G * g + CR_B * b) / Q16 + OFFSET);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        yuv_t want;
        if (!rst_n)
        begin
            red_shift_reg   <= rgb2yuv_pkg::RED_SHIFT_RESET;
            red_loss_reg    <= rgb2yuv_pkg::RED_LOSS_RESET;
            green_shift_reg <= rgb2yuv_pkg::GREEN_SHIFT_RESET;
            green_loss_reg  <= rgb2yuv_pkg::GREEN_LOSS_RESET;
            blue_shift_reg  <= rgb2yuv_pkg::BLUE_SHIFT_RESET;
            blue_loss_reg   <= rgb2yuv_pkg::BLUE_LOSS_RESET;
            yuv_expected.delete();
            outstanding     <= 0;
        end
        else
        begin
            if ($isunknown(done))
            begin
                err_count++;
                $display("%0t: done expected known actual %b", $time, done);
            end
            else if (done)
            begin
                if (yuv_expected.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result expected none actual %0d %0d %0d",
                             $time, luma, chroma_blue, chroma_red);
                end
                else
                begin
                    want = yuv_expected.pop_front();
                    check_field("luma", want.luma, luma);
                    check_field("chroma_blue", want.cb, chroma_blue);
                    check_field("chroma_red", want.cr, chroma_red);
                end
            end
            // pixel transaction
            if (start && !busy)
                yuv_expected.push_back(convert(pixel));
            if (write_enable)
            begin
                case (write_index)
                    rgb2yuv_pkg::REG_RED_SHIFT:   red_shift_reg   <= write_data;
                    rgb2yuv_pkg::REG_RED_LOSS:    red_loss_reg    <= write_data;
                    rgb2yuv_pkg::REG_GREEN_SHIFT: green_shift_reg <= write_data;
                    rgb2yuv_pkg::REG_GREEN_LOSS:  green_loss_reg  <= write_data;
                    rgb2yuv_pkg::REG_BLUE_SHIFT:  blue_shift_reg  <= write_data;
                    rgb2yuv_pkg::REG_BLUE_LOSS:   blue_loss_reg   <= write_data;
                    default:                      ;
                endcase
            end
            outstanding <= yuv_expected.size();
        end
    end

endmodule

[bench/tb_rgb16_to_yuv_convert.sv]
`timescale 1ns / 1ps
module tb_rgb16_to_yuv_convert;

    localparam int PIXEL_WIDTH    = rgb2yuv_pkg::PixelWidthDefault;
    localparam int IW             = rgb2yuv_pkg::CfgIndexWidth;
    localparam int DW             = rgb2yuv_pkg::CfgDataWidth;
    localparam int CW             = rgb2yuv_pkg::ChanWidth;
    localparam int SEGMENTS       = 7;
    localparam int SEGMENT_PIXELS = 49;
    localparam int MAX_GAP        = 40;
    localparam int DRAIN_CYCLES   = 10;

    // indexes with no register behind them
    localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   start        = 1'b0;
    logic [PIXEL_WIDTH-1:0] pixel        = '0;
    logic                   write_enable = 1'b0;
    logic [IW-1:0]          write_index  = '0;
    logic [DW-1:0]          write_data   = '0;
    logic                   busy;
    logic                   done;
    logic [CW-1:0]          luma;
    logic [CW-1:0]          chroma_blue;
    logic [CW-1:0]          chroma_red;
    int                     outstanding;
    int                     mismatches;
    int                     sender_idle_pct = 38;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb16_to_yuv_convert #(
        .PIXEL_WIDTH(PIXEL_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .write_enable(write_enable),
        .write_index(write_index),
        .write_data(write_data),
        .done(done),
        .luma(luma),
        .chroma_blue(chroma_blue),
        .chroma_red(chroma_red)
    );

    rgb16_yuv_checker #(
        .PIXEL_WIDTH(PIXEL_WIDTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .write_enable(write_enable),
        .write_index(write_index),
        .write_data(write_data),
        .done(done),
        .luma(luma),
        .chroma_blue(chroma_blue),
        .chroma_red(chroma_red),
        .outstanding(outstanding),
        .mismatches(mismatches)
    );

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_pixel(input logic [PIXEL_WIDTH-1:0] value);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pixel <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // all six registers back to back, then both unused indexes
    task automatic write_layout(input logic [DW-1:0] rs, rl, gs, gl, bs, bl);
        logic [IW-1:0] idx [8];
        logic [DW-1:0] val [8];
        idx = '{rgb2yuv_pkg::REG_RED_SHIFT, rgb2yuv_pkg::REG_RED_LOSS,
                rgb2yuv_pkg::REG_GREEN_SHIFT, rgb2yuv_pkg::REG_GREEN_LOSS,
                rgb2yuv_pkg::REG_BLUE_SHIFT, rgb2yuv_pkg::REG_BLUE_LOSS,
                REG_SPARE_LO, REG_SPARE_HI};
        val = '{rs, rl, gs, gl, bs, bl,
                DW'($urandom), DW'($urandom)};
        for (int i = 0; i < 8; i++)
        begin
            write_enable <= 1'b1;
            write_index  <= idx[i];
            write_data   <= val[i];
            @(posedge clk);
        end
        write_enable <= 1'b0;
    endtask

    // mostly sensible losses, now and then one that empties the channel
    function automatic logic [DW-1:0] random_loss();
        if ($urandom_range(7) == 0)
            return DW'($urandom_range(15, 9));
        return DW'($urandom_range(8));
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 565 layout out of reset
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        send_pixel(16'h8000);
        send_pixel(16'h0001);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
        send_pixel(16'h7BEF);
        drain();

        // red field running off the top of the pixel
        write_layout(4'd15, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);
        send_pixel(16'h00FF);
        drain();

        // loss of eight and above empties a channel
        write_layout(4'd0, 4'd8, 4'd4, 4'd15, 4'd12, 4'd0);
        send_pixel(16'hFFFF);
        send_pixel(16'hF000);
        drain();

        // full bytes, chroma sums going negative
        write_layout(4'd0, 4'd0, 4'd8, 4'd0, 4'd8, 4'd0);
        send_pixel(16'h00FF);
        send_pixel(16'hFF00);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 51 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                if (seg == 0)
                    write_layout(rgb2yuv_pkg::RED_SHIFT_RESET,
                                 rgb2yuv_pkg::RED_LOSS_RESET,
                                 rgb2yuv_pkg::GREEN_SHIFT_RESET,
                                 rgb2yuv_pkg::GREEN_LOSS_RESET,
                                 rgb2yuv_pkg::BLUE_SHIFT_RESET,
                                 rgb2yuv_pkg::BLUE_LOSS_RESET);
                else
                    write_layout(DW'($urandom_range(15)), random_loss(),
                                 DW'($urandom_range(15)), random_loss(),
                                 DW'($urandom_range(15)), random_loss());
                for (int n = 0; n < SEGMENT_PIXELS; n++)
                begin
                    logic [PIXEL_WIDTH-1:0] value;
                    case ($urandom_range(9))
                        0:       value = '0;
                        1:       value = '1;
                        2:       value = PIXEL_WIDTH'(1) << $urandom_range(PIXEL_WIDTH - 1);
                        default: value = PIXEL_WIDTH'($urandom);
                    endcase
                    send_pixel(value);
                    if ($urandom_range(199) == 0)
                        drain();
                end
                drain();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
